// ===== rtl/rl_pkg.sv =====
`timescale 1ns / 1ps
package rl_pkg;

    localparam int NUM_USERS = 64;
    localparam int USER_W    = 6;
    localparam int MAX_MSGS  = 64;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 7;
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 31;
    localparam int STAT_W    = 32;
    localparam int ALL_W     = 38;
    localparam int TOT_W     = 39;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 31;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_QUERY  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW  = 2'd0,
        CFG_LIMIT   = 2'd1,
        CFG_PENALTY = 2'd2,
        CFG_SOFT    = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_EV,
        S_EVC,
        S_FULL,
        S_PUSH,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [USER_W-1:0] user;
        logic [TIME_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic [DUR_W-1:0] win;
        logic [CNT_W-1:0] limit;
        logic [DUR_W-1:0] pen;
        logic             soft_on;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] pend;
        logic              pflag;
        logic [STAT_W-1:0] sent;
        logic [STAT_W-1:0] drop;
    } rec_t;

    typedef struct packed {
        logic              allowed;
        logic [STAT_W-1:0] sent;
        logic [STAT_W-1:0] dropped;
        logic [CNT_W-1:0]  wcount;
        logic              pen;
        logic [ALL_W-1:0]  all;
    } res_t;

    // True if a lies strictly after b, modulo the time width.
    function automatic logic time_after(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[TIME_W-1];
    endfunction

endpackage

// ===== rtl/rl_if.sv =====
`timescale 1ns / 1ps
interface rl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [5:0]  user_id;
    logic [31:0] now_ms;
    modport source (output valid, output op, output user_id, output now_ms, input ready);
    modport sink (input valid, input op, input user_id, input now_ms, output ready);
endinterface

interface rl_out_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [31:0] user_sent;
    logic [31:0] user_dropped;
    logic [6:0]  window_count;
    logic        in_penalty;
    logic [37:0] all_drops;
    modport source (output valid, output allowed, output user_sent, output user_dropped,
                    output window_count, output in_penalty, output all_drops, input ready);
    modport sink (input valid, input allowed, input user_sent, input user_dropped,
                  input window_count, input in_penalty, input all_drops, output ready);
endinterface

// ===== rtl/rl_front.sv =====
`timescale 1ns / 1ps
module rl_front (
    input  logic          clk,
    input  logic          rst_n,
    rl_in_if.sink         in_ch,
    output logic          q_valid,
    output rl_pkg::item_t q_item,
    input  logic          q_pop
);
    import rl_pkg::*;

    item_t       slot_reg [2];
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    logic        pop;
    item_t       in_item;

    always_comb
    begin
        in_item.op   = op_t'(in_ch.op);
        in_item.user = in_ch.user_id;
        in_item.now  = in_ch.now_ms;
    end

    assign in_ch.ready = (fill_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (fill_reg != 2'd0);
    assign pop         = q_pop && q_valid;
    assign q_item      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/rl_back.sv =====
`timescale 1ns / 1ps
module rl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  rl_pkg::cfg_t  cfg,
    input  logic          q_valid,
    input  rl_pkg::item_t q_item,
    output logic          q_pop,
    rl_out_if.source      out_ch
);
    import rl_pkg::*;

    rec_t              rec_mem [NUM_USERS];
    logic [TIME_W-1:0] stamp_mem [NUM_USERS*MAX_MSGS];

    state_t            st_reg, st_next;
    item_t             cur_reg, cur_next;
    rec_t              wk_reg, wk_next;
    logic              allowed_reg, allowed_next;
    logic [NUM_USERS-1:0] vld_reg, vld_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    rec_t              rec_rd_reg;
    logic              vld_rd_reg;
    logic [TIME_W-1:0] stamp_rd_reg;

    logic              rec_we;
    logic              st_we;
    logic [USER_W+SLOT_W-1:0] st_raddr;
    logic [USER_W+SLOT_W-1:0] st_waddr;
    logic [CNT_W-1:0]  lim;
    logic [TIME_W-1:0] age;
    logic              out_free;

    always_comb
    begin
        if (cfg.limit == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (cfg.limit > CNT_W'(MAX_MSGS))
        begin
            lim = CNT_W'(MAX_MSGS);
        end
        else
        begin
            lim = cfg.limit;
        end
    end

    assign age      = cur_reg.now - stamp_rd_reg;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign st_raddr = {cur_reg.user, wk_reg.head};
    assign st_waddr = {cur_reg.user, wk_reg.head + wk_reg.count[SLOT_W-1:0]};

    always_comb
    begin
        st_next        = st_reg;
        cur_next       = cur_reg;
        wk_next        = wk_reg;
        allowed_next   = allowed_reg;
        vld_next       = vld_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        rec_we         = 1'b0;
        st_we          = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    st_next  = S_RD;
                end
            end
            S_RD:
            begin
                wk_next      = vld_rd_reg ? rec_rd_reg : '0;
                allowed_next = 1'b0;
                if (cur_reg.op == OP_REMOVE)
                begin
                    if (vld_rd_reg)
                    begin
                        total_next = total_reg - {{(TOT_W-STAT_W){1'b0}}, rec_rd_reg.drop};
                    end
                    wk_next = '0;
                end
                st_next = (cur_reg.op == OP_CHECK) ? S_CHK : S_DONE;
            end
            S_CHK:
            begin
                if (wk_reg.pflag && time_after(wk_reg.pend, cur_reg.now))
                begin
                    if (wk_reg.drop != '1)
                    begin
                        wk_next.drop = wk_reg.drop + 1'b1;
                        total_next   = total_reg + 1'b1;
                    end
                    st_next = S_DONE;
                end
                else
                begin
                    wk_next.pflag = 1'b0;
                    st_next       = S_EV;
                end
            end
            S_EV:
            begin
                st_next = (wk_reg.count == '0) ? S_FULL : S_EVC;
            end
            S_EVC:
            begin
                if (!age[TIME_W-1] && (age > {1'b0, cfg.win}))
                begin
                    wk_next.head  = wk_reg.head + 1'b1;
                    wk_next.count = wk_reg.count - 1'b1;
                end
                st_next = (!age[TIME_W-1] && (age > {1'b0, cfg.win})) ? S_EV : S_FULL;
            end
            S_FULL:
            begin
                st_next = S_PUSH;
                if (wk_reg.count >= lim)
                begin
                    if (!cfg.soft_on)
                    begin
                        wk_next.pend  = cur_reg.now + {1'b0, cfg.pen};
                        wk_next.pflag = 1'b1;
                        if (wk_reg.drop != '1)
                        begin
                            wk_next.drop = wk_reg.drop + 1'b1;
                            total_next   = total_reg + 1'b1;
                        end
                        st_next = S_DONE;
                    end
                    else
                    begin
                        wk_next.head  = wk_reg.head
                                      + SLOT_W'(wk_reg.count - lim + CNT_W'(1));
                        wk_next.count = lim - CNT_W'(1);
                    end
                end
            end
            S_PUSH:
            begin
                st_we         = 1'b1;
                wk_next.count = wk_reg.count + 1'b1;
                if (wk_reg.sent != '1)
                begin
                    wk_next.sent = wk_reg.sent + 1'b1;
                end
                allowed_next = 1'b1;
                st_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    st_next        = S_IDLE;
                    if (cur_reg.op == OP_CLEAR)
                    begin
                        vld_next   = '0;
                        total_next = '0;
                        out_next   = '0;
                    end
                    else
                    begin
                        rec_we = 1'b1;
                        vld_next[cur_reg.user] = (cur_reg.op != OP_REMOVE);
                        out_next.allowed = allowed_reg;
                        out_next.sent    = wk_reg.sent;
                        out_next.dropped = wk_reg.drop;
                        out_next.wcount  = wk_reg.count;
                        out_next.pen     = wk_reg.pflag && time_after(wk_reg.pend, cur_reg.now);
                        out_next.all     = total_reg[TOT_W-1] ? '1 : total_reg[ALL_W-1:0];
                    end
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            vld_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            vld_reg       <= vld_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        wk_reg      <= wk_next;
        allowed_reg <= allowed_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[cur_reg.user] <= wk_reg;
        end
        rec_rd_reg <= rec_mem[q_item.user];
        vld_rd_reg <= vld_reg[q_item.user];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stamp_mem[st_waddr] <= cur_reg.now;
        end
        stamp_rd_reg <= stamp_mem[st_raddr];
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.allowed      = out_reg.allowed;
    assign out_ch.user_sent    = out_reg.sent;
    assign out_ch.user_dropped = out_reg.dropped;
    assign out_ch.window_count = out_reg.wcount;
    assign out_ch.in_penalty   = out_reg.pen;
    assign out_ch.all_drops    = out_reg.all;

    a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_EVC |-> wk_reg.count != '0)
        else $error("eviction compare with an empty ring");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_PUSH |-> wk_reg.count < lim)
        else $error("push into a full ring");

    a_allowed_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.allowed |-> out_reg.wcount != '0)
        else $error("allowed item left an empty ring");

endmodule

// ===== rtl/per_user_sliding_window_rate_limiter.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                                                      Handshake
// in_ch    in   op, user_id, now_ms                                          valid/ready
// out_ch   out  allowed, user_sent, user_dropped, window_count,
//               in_penalty, all_drops                                        valid/ready
// cfg      in   cfg_index, cfg_data                                          cfg_we
//
// A check runs read, penalty, eviction, fill, push and done; an empty ring skips the
// compare, a hard drop the push, and each evicted timestamp repeats eviction and compare.
// A check in a penalty goes to done; query, remove and clear go from read to done.
// The back end waits while the result register is full; the eviction loop is bound by the
// registered timestamp read. Reset clears all users at once through per-user valid bits.
// No clearing pass; a two-item queue holds input while the back end or output stalls.
module per_user_sliding_window_rate_limiter (
    input  logic                         clk,
    input  logic                         rst_n,
    rl_in_if.sink                        in_ch,
    rl_out_if.source                     out_ch,
    input  logic                         cfg_we,
    input  logic [rl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rl_pkg::CFG_W-1:0]     cfg_data
);
    import rl_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WINDOW:  cfg_next.win     = cfg_data;
                CFG_LIMIT:   cfg_next.limit   = cfg_data[CNT_W-1:0];
                CFG_PENALTY: cfg_next.pen     = cfg_data;
                CFG_SOFT:    cfg_next.soft_on = cfg_data[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win     <= DUR_W'(1000);
            cfg_reg.limit   <= CNT_W'(10);
            cfg_reg.pen     <= '0;
            cfg_reg.soft_on <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    rl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule
